/* rtl/rbef_pkg.sv */
package rbef_pkg;

    localparam logic [1:0] CFG_HALF_WIDTH = 2'd0;
    localparam logic [1:0] CFG_TOP_Z      = 2'd1;
    localparam logic [1:0] CFG_BOTTOM_Z   = 2'd2;

    localparam logic [22:0] RST_HALF_WIDTH = 23'd13440;
    localparam logic [23:0] RST_TOP_Z      = 24'd12800;
    localparam logic [23:0] RST_BOTTOM_Z   = 24'hFFFCE0;

    localparam logic [2:0] FACE_TOP    = 3'd0;
    localparam logic [2:0] FACE_POS_X  = 3'd1;
    localparam logic [2:0] FACE_POS_Y  = 3'd2;
    localparam logic [2:0] FACE_NEG_X  = 3'd3;
    localparam logic [2:0] FACE_NEG_Y  = 3'd4;
    localparam logic [2:0] FACE_BOTTOM = 3'd5;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

endpackage

/* rtl/ray_box_exit_face_unit.sv */
// Channel  Direction  Signals                          Contents
// s_axis   in         i_s_axis_tvalid/o_s_axis_tready  track: position, direction, up flag
// m_axis   out        o_m_axis_tvalid/i_m_axis_tready  exit: valid flag, face, length, point
// cfg      in         i_cfg_valid/o_cfg_ready          register index and write data
//
// One track per cycle while the output is not stalled. The three restoring dividers
// resolve one quotient bit per stage.
// Reset (synchronous, active low) clears stage valid bits and loads register defaults.
// A stall at the output holds every stage; nothing is lost or repeated.
module ray_box_exit_face_unit
    import rbef_pkg::*;
#(
    parameter int POS_BITS      = 24,
    parameter int DIR_FRAC_BITS = 15
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z
    input  logic [((3*POS_BITS+3*(DIR_FRAC_BITS+1)+7)/8)*8-1:0] i_s_axis_tdata,
    // upward
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // face, path_length, exit_x, exit_y, exit_z
    output logic [135:0] o_m_axis_tdata,
    // valid_exit
    output logic         o_m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data
);

    localparam int DIRW  = DIR_FRAC_BITS + 1;
    localparam int DW    = ((POS_BITS > 24) ? POS_BITS : 24) + 1;
    localparam int NW    = DW + DIR_FRAC_BITS;
    localparam int MW    = 32 + DIRW;
    localparam int SW    = 34;
    localparam int IDX_C = NW + 1;
    localparam int IDX_D = NW + 2;
    localparam int IDX_E = NW + 3;
    localparam int IDX_F = NW + 4;
    localparam int IDX_G = NW + 5;
    localparam int NS    = NW + 6;
    localparam logic [MW-1:0] BIAS = MW'((64'd1 << DIR_FRAC_BITS) - 64'd1);

    typedef struct packed {
        logic signed [POS_BITS-1:0] px;
        logic signed [POS_BITS-1:0] py;
        logic signed [POS_BITS-1:0] pz;
        logic signed [DIRW-1:0]     dx;
        logic signed [DIRW-1:0]     dy;
        logic signed [DIRW-1:0]     dz;
        logic                       up;
        logic                       bad_dir;
        logic [2:0]                 negq;
        logic [2:0]                 dnz;
        logic                       dneg_z;
        logic signed [31:0]         s;
        logic [2:0]                 face;
        logic                       ok;
    } t_trk;

    function automatic logic signed [31:0] sat_len(input logic [NW-1:0] q, input logic neg);
        logic [31:0] lo;
        lo = q[31:0];
        if (!neg) begin
            return (|q[NW-1:31]) ? SAT_MAX : lo;
        end else if ((|q[NW-1:32]) || (q[31] && (|q[30:0]))) begin
            return SAT_MIN;
        end
        return -lo;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        if (!v[SW-1] && (|v[SW-2:31])) begin
            return SAT_MAX;
        end else if (v[SW-1] && !(&v[SW-2:31])) begin
            return SAT_MIN;
        end
        return v[31:0];
    endfunction

    logic        [22:0] r_hw;
    logic signed [23:0] r_top;
    logic signed [23:0] r_bot;

    logic en;
    logic r_vld [NS];
    t_trk r_trk [NS];

    logic signed [POS_BITS-1:0] in_px, in_py, in_pz;
    logic signed [DIRW-1:0]     in_dx, in_dy, in_dz;
    logic signed [DW-1:0]       hw_ext, dist_x, dist_y, dist_z;
    logic        [DW-1:0]       mag_x, mag_y, mag_z;
    logic        [DIRW-1:0]     n_den_x, n_den_y, n_den_z;
    t_trk                       n_trk_a;

    logic [NW-1:0] r_num_x, r_num_y, r_num_z;
    logic [DIRW-1:0] r_den_x, r_den_y, r_den_z;
    logic [NW-1:0] quo_x, quo_y, quo_z;

    logic signed [31:0] n_sx, n_sy, n_sz;
    logic signed [31:0] r_sx, r_sy, r_sz;
    t_trk               n_trk_d;

    logic signed [MW-1:0] r_prod_x, r_prod_y, r_prod_z;
    logic        [MW-1:0] biased_x, biased_y, biased_z;
    logic signed [32:0]   r_step_x, r_step_y, r_step_z;
    logic signed [SW-1:0] sum_x, sum_y, sum_z;

    logic        [2:0]  r_o_face;
    logic signed [31:0] r_o_path, r_o_x, r_o_y, r_o_z;
    logic               r_o_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw  <= RST_HALF_WIDTH;
            r_top <= RST_TOP_Z;
            r_bot <= RST_BOTTOM_Z;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HALF_WIDTH: r_hw  <= i_cfg_data[22:0];
                CFG_TOP_Z:      r_top <= i_cfg_data;
                CFG_BOTTOM_Z:   r_bot <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en              = !r_vld[IDX_G] || i_m_axis_tready;
    assign o_s_axis_tready = en;

    assign in_px = i_s_axis_tdata[POS_BITS-1:0];
    assign in_py = i_s_axis_tdata[2*POS_BITS-1:POS_BITS];
    assign in_pz = i_s_axis_tdata[3*POS_BITS-1:2*POS_BITS];
    assign in_dx = i_s_axis_tdata[3*POS_BITS+DIRW-1:3*POS_BITS];
    assign in_dy = i_s_axis_tdata[3*POS_BITS+2*DIRW-1:3*POS_BITS+DIRW];
    assign in_dz = i_s_axis_tdata[3*POS_BITS+3*DIRW-1:3*POS_BITS+2*DIRW];

    assign hw_ext = {{(DW-23){1'b0}}, r_hw};

    always_comb begin
        dist_x = (in_dx[DIRW-1] ? -hw_ext : hw_ext)
                 - {{(DW-POS_BITS){in_px[POS_BITS-1]}}, in_px};
        dist_y = (in_dy[DIRW-1] ? -hw_ext : hw_ext)
                 - {{(DW-POS_BITS){in_py[POS_BITS-1]}}, in_py};
        dist_z = (i_s_axis_tuser ? {{(DW-24){r_top[23]}}, r_top}
                                 : {{(DW-24){r_bot[23]}}, r_bot})
                 - {{(DW-POS_BITS){in_pz[POS_BITS-1]}}, in_pz};
        mag_x   = dist_x[DW-1] ? -dist_x : dist_x;
        mag_y   = dist_y[DW-1] ? -dist_y : dist_y;
        mag_z   = dist_z[DW-1] ? -dist_z : dist_z;
        n_den_x = in_dx[DIRW-1] ? -in_dx : in_dx;
        n_den_y = in_dy[DIRW-1] ? -in_dy : in_dy;
        n_den_z = in_dz[DIRW-1] ? -in_dz : in_dz;

        n_trk_a         = '0;
        n_trk_a.px      = in_px;
        n_trk_a.py      = in_py;
        n_trk_a.pz      = in_pz;
        n_trk_a.dx      = in_dx;
        n_trk_a.dy      = in_dy;
        n_trk_a.dz      = in_dz;
        n_trk_a.up      = i_s_axis_tuser;
        n_trk_a.bad_dir = i_s_axis_tuser ? in_dz[DIRW-1] : (!in_dz[DIRW-1] && (|in_dz));
        n_trk_a.negq    = {dist_z[DW-1] ^ in_dz[DIRW-1],
                           dist_y[DW-1] ^ in_dy[DIRW-1],
                           dist_x[DW-1] ^ in_dx[DIRW-1]};
        n_trk_a.dnz     = {|dist_z, |dist_y, |dist_x};
        n_trk_a.dneg_z  = dist_z[DW-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num_x <= {mag_x, {DIR_FRAC_BITS{1'b0}}};
            r_num_y <= {mag_y, {DIR_FRAC_BITS{1'b0}}};
            r_num_z <= {mag_z, {DIR_FRAC_BITS{1'b0}}};
            r_den_x <= n_den_x;
            r_den_y <= n_den_y;
            r_den_z <= n_den_z;
        end
    end

    rbef_div #(.NUM_W(NW), .DEN_W(DIRW)) u_div_x (
        .i_clk(i_clk), .i_en(en), .i_num(r_num_x), .i_den(r_den_x), .o_quo(quo_x)
    );
    rbef_div #(.NUM_W(NW), .DEN_W(DIRW)) u_div_y (
        .i_clk(i_clk), .i_en(en), .i_num(r_num_y), .i_den(r_den_y), .o_quo(quo_y)
    );
    rbef_div #(.NUM_W(NW), .DEN_W(DIRW)) u_div_z (
        .i_clk(i_clk), .i_en(en), .i_num(r_num_z), .i_den(r_den_z), .o_quo(quo_z)
    );

    always_comb begin
        n_sx = (r_trk[NW].dx == '0) ? (r_trk[NW].dnz[0] ? SAT_MAX : '0)
                                    : sat_len(quo_x, r_trk[NW].negq[0]);
        n_sy = (r_trk[NW].dy == '0) ? (r_trk[NW].dnz[1] ? SAT_MAX : '0)
                                    : sat_len(quo_y, r_trk[NW].negq[1]);
        if (r_trk[NW].dz == '0) begin
            n_sz = !r_trk[NW].dnz[2] ? '0 : (r_trk[NW].dneg_z ? SAT_MIN : SAT_MAX);
        end else begin
            n_sz = sat_len(quo_z, r_trk[NW].negq[2]);
        end
    end

    always_comb begin
        n_trk_d = r_trk[IDX_C];
        if (r_sx < r_sy && r_sx < r_sz) begin
            n_trk_d.s    = r_sx;
            n_trk_d.face = (r_trk[IDX_C].dx > 0) ? FACE_POS_X : FACE_NEG_X;
        end else if (!(r_sx < r_sy) && r_sy < r_sz) begin
            n_trk_d.s    = r_sy;
            n_trk_d.face = (r_trk[IDX_C].dy > 0) ? FACE_POS_Y : FACE_NEG_Y;
        end else begin
            n_trk_d.s    = r_sz;
            n_trk_d.face = r_trk[IDX_C].up ? FACE_TOP : FACE_BOTTOM;
        end
        n_trk_d.ok = !r_trk[IDX_C].bad_dir && !n_trk_d.s[31];
    end

    assign biased_x = r_prod_x + (r_prod_x[MW-1] ? BIAS : '0);
    assign biased_y = r_prod_y + (r_prod_y[MW-1] ? BIAS : '0);
    assign biased_z = r_prod_z + (r_prod_z[MW-1] ? BIAS : '0);

    assign sum_x = {{(SW-POS_BITS){r_trk[IDX_F].px[POS_BITS-1]}}, r_trk[IDX_F].px}
                   + {{(SW-33){r_step_x[32]}}, r_step_x};
    assign sum_y = {{(SW-POS_BITS){r_trk[IDX_F].py[POS_BITS-1]}}, r_trk[IDX_F].py}
                   + {{(SW-33){r_step_y[32]}}, r_step_y};
    assign sum_z = {{(SW-POS_BITS){r_trk[IDX_F].pz[POS_BITS-1]}}, r_trk[IDX_F].pz}
                   + {{(SW-33){r_step_z[32]}}, r_step_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k < NS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_trk[0] <= n_trk_a;
            for (int k = 1; k < NS; k++) begin
                r_trk[k] <= (k == IDX_D) ? n_trk_d : r_trk[k-1];
            end
            r_sx <= n_sx;
            r_sy <= n_sy;
            r_sz <= n_sz;
            r_prod_x <= r_trk[IDX_D].s * r_trk[IDX_D].dx;
            r_prod_y <= r_trk[IDX_D].s * r_trk[IDX_D].dy;
            r_prod_z <= r_trk[IDX_D].s * r_trk[IDX_D].dz;
            r_step_x <= biased_x[MW-1:DIR_FRAC_BITS];
            r_step_y <= biased_y[MW-1:DIR_FRAC_BITS];
            r_step_z <= biased_z[MW-1:DIR_FRAC_BITS];
            r_o_ok   <= r_trk[IDX_F].ok;
            if (r_trk[IDX_F].ok) begin
                r_o_face <= r_trk[IDX_F].face;
                r_o_path <= r_trk[IDX_F].up ? r_trk[IDX_F].s : -r_trk[IDX_F].s;
                r_o_x    <= sat32(sum_x);
                r_o_y    <= sat32(sum_y);
                r_o_z    <= sat32(sum_z);
            end else begin
                r_o_face <= FACE_TOP;
                r_o_path <= '0;
                r_o_x    <= '0;
                r_o_y    <= '0;
                r_o_z    <= '0;
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[IDX_G];
    assign o_m_axis_tuser  = r_o_ok;
    assign o_m_axis_tdata  = {5'b0, r_o_z, r_o_y, r_o_x, r_o_path, r_o_face};

endmodule

/* rtl/rbef_div.sv */
module rbef_div
    import rbef_pkg::*;
#(
    parameter int NUM_W = 40,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [NUM_W-1:0] r_quo [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W-1];
    logic [DEN_W-1:0] r_den [NUM_W-1];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [NUM_W-1:0] quo_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] n_rem;
        logic [NUM_W-1:0] n_quo;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = i_num;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
            assign den_in = r_den[k-1];
        end

        assign trial = {rem_in, quo_in[NUM_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = (trial >= {1'b0, den_in});
        assign n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign n_quo = {quo_in[NUM_W-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= n_quo;
            end
        end

        if (k < NUM_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_quo[NUM_W-1];

endmodule
